>>> src/mxy_pkg.sv
// Package for the mesh XY route computation block.
// Holds field widths, port-mask bit positions, register indexes and the divider step.
// No dependencies.
`timescale 1ns / 1ps

package mxy_pkg;

   // Field widths.
   localparam int NODE_W     = 12;
   localparam int DIM_W      = 7;
   localparam int MASK_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Default upper limit on a mesh dimension.
   localparam int MAX_DIM_DEF = 64;

   // The divider retires this many quotient bits in each pipeline stage.
   localparam int DIV_BITS   = 3;
   localparam int DIV_STAGES = NODE_W / DIV_BITS;

   // Bit positions in the port mask.
   localparam int PORT_LOCAL = 0;
   localparam int PORT_WEST  = 1;
   localparam int PORT_EAST  = 2;
   localparam int PORT_SOUTH = 3;
   localparam int PORT_NORTH = 4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MESH_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MESH_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE    = 2'd2;

   // Partial division: the dividend shifts out at the top while quotient bits
   // shift in at the bottom, and the remainder stays below the divisor.
   typedef struct packed {
      logic [NODE_W-1:0] num;
      logic [DIM_W-1:0]  rem;
   } div_type;

   // One request as it moves through the divider stages.
   typedef struct packed {
      logic             bcast;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      div_type          own;
      div_type          key;
   } stage_type;

   // Restoring division over DIV_BITS dividend bits.
   function automatic div_type div_step(div_type cur, logic [DIM_W-1:0] divisor);
      div_type        res;
      logic [DIM_W:0] rem_sh;
      res = cur;
      for (int i = 0; i < DIV_BITS; i++) begin
         rem_sh  = {res.rem, res.num[NODE_W-1]};
         res.num = {res.num[NODE_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, divisor}) begin
            rem_sh     = rem_sh - {1'b0, divisor};
            res.num[0] = 1'b1;
         end
         res.rem = rem_sh[DIM_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> src/mesh_xy_route_compute.sv
// Route computation for one mesh router: XY unicast and tree broadcast.
// A request passes the input register, the divider stages and the output register in turn.
// Throughput: one request per cycle unless a stall on rsp_ready backs up to the input; a
// pipelined divider of four stages, three quotient bits each, splits node ids into coordinates.
// Reset (synchronous): pipeline empty, width 8, height 8, own node 0.
// Depends on mxy_pkg.
`timescale 1ns / 1ps

module mesh_xy_route_compute #(
   parameter int MAX_DIM = mxy_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mxy_pkg::NODE_W-1:0]      req_src_node,
   input  logic [mxy_pkg::NODE_W-1:0]      req_dst_node,
   input  logic                            req_is_broadcast,
   // Response channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mxy_pkg::MASK_W-1:0]      rsp_port_mask,
   output logic                            rsp_route_error,
   // Configuration write port.
   input  logic                            csr_wr_en,
   input  logic [mxy_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mxy_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import mxy_pkg::*;

   // Stage 0 is the input register, stages 1..DIV_STAGES divide, the last is the output.
   localparam int NUM_STAGES = DIV_STAGES + 2;
   localparam int LAST       = NUM_STAGES - 1;
   // Register values never exceed the register range, so the limit folds into it.
   localparam int DIM_LIMIT  = (MAX_DIM > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_DIM;
   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(DIM_LIMIT);

   logic [DIM_W-1:0]  mesh_width_ff;
   logic [DIM_W-1:0]  mesh_height_ff;
   logic [NODE_W-1:0] own_node_ff;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] adv;
   stage_type             stage_ff [DIV_STAGES+1];
   stage_type             stage_in [DIV_STAGES+1];

   logic [MASK_W-1:0] port_mask_ff;
   logic [MASK_W-1:0] port_mask_in;
   logic              route_error_ff;
   logic              route_error_in;
   logic              bcast_out_ff;

   // Zero reads as one, anything above the limit as the limit.
   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mesh_width_ff  <= DIM_W'(8);
         mesh_height_ff <= DIM_W'(8);
         own_node_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MESH_WIDTH:  mesh_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_MESH_HEIGHT: mesh_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_OWN_NODE:    own_node_ff    <= csr_wdata[NODE_W-1:0];
            default: ;
         endcase
      end
   end

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      adv[LAST] = !valid_ff[LAST] || rsp_ready;
      for (int s = LAST - 1; s >= 0; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   assign req_ready = adv[0];

   // Stage inputs: capture the request, then divide a few bits per stage.
   always_comb begin
      stage_in[0].bcast   = req_is_broadcast;
      stage_in[0].width   = clamp_dim(mesh_width_ff);
      stage_in[0].height  = clamp_dim(mesh_height_ff);
      stage_in[0].own.num = own_node_ff;
      stage_in[0].own.rem = '0;
      stage_in[0].key.num = req_is_broadcast ? req_src_node : req_dst_node;
      stage_in[0].key.rem = '0;
      for (int s = 1; s <= DIV_STAGES; s++) begin
         stage_in[s]     = stage_ff[s-1];
         stage_in[s].own = div_step(stage_ff[s-1].own, stage_ff[s-1].width);
         stage_in[s].key = div_step(stage_ff[s-1].key, stage_ff[s-1].width);
      end
   end

   // Route decision on the finished coordinates.
   always_comb begin
      logic [DIM_W-1:0]  w;
      logic [NODE_W:0]   h;
      logic [DIM_W-1:0]  cx;
      logic [DIM_W-1:0]  kx;
      logic [NODE_W:0]   cy;
      logic [NODE_W:0]   ky;
      logic              row_ok;
      logic              north_ok;
      logic              south_ok;
      logic              east_ok;
      logic              west_ok;
      w  = stage_ff[DIV_STAGES].width;
      h  = (NODE_W+1)'(stage_ff[DIV_STAGES].height);
      cx = stage_ff[DIV_STAGES].own.rem;
      cy = {1'b0, stage_ff[DIV_STAGES].own.num};
      kx = stage_ff[DIV_STAGES].key.rem;
      ky = {1'b0, stage_ff[DIV_STAGES].key.num};

      // The own column is always inside the mesh, so only rows need checking.
      row_ok   = cy < h;
      north_ok = (cy + (NODE_W+1)'(1)) < h;
      south_ok = (cy != '0) && (cy <= h);
      east_ok  = row_ok && (({1'b0, cx} + (DIM_W+1)'(1)) < {1'b0, w});
      west_ok  = row_ok && (cx != '0);

      port_mask_in   = '0;
      route_error_in = 1'b0;
      if (stage_ff[DIV_STAGES].bcast) begin
         port_mask_in[PORT_LOCAL] = 1'b1;
         port_mask_in[PORT_NORTH] = (cy >= ky) && north_ok;
         port_mask_in[PORT_SOUTH] = (cy <= ky) && south_ok;
         if (cy == ky) begin
            port_mask_in[PORT_EAST] = (cx >= kx) && east_ok;
            port_mask_in[PORT_WEST] = (cx <= kx) && west_ok;
         end
      end else begin
         // X first, then Y; a hop off the mesh reports an error.
         priority if (cx > kx) begin
            port_mask_in[PORT_WEST] = west_ok;
            route_error_in          = !west_ok;
         end else if (cx < kx) begin
            port_mask_in[PORT_EAST] = east_ok;
            route_error_in          = !east_ok;
         end else if (cy > ky) begin
            port_mask_in[PORT_SOUTH] = south_ok;
            route_error_in           = !south_ok;
         end else if (cy < ky) begin
            port_mask_in[PORT_NORTH] = north_ok;
            route_error_in           = !north_ok;
         end else begin
            port_mask_in[PORT_LOCAL] = 1'b1;
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (adv[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
         if (adv[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
      if (adv[LAST]) begin
         port_mask_ff   <= port_mask_in;
         route_error_ff <= route_error_in;
         bcast_out_ff   <= stage_ff[DIV_STAGES].bcast;
      end
   end

   assign rsp_valid       = valid_ff[LAST];
   assign rsp_port_mask   = port_mask_ff;
   assign rsp_route_error = route_error_ff;

   // A finished division leaves remainders below the mesh width.
   a_rem_below_width: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_STAGES] |-> (stage_ff[DIV_STAGES].own.rem < stage_ff[DIV_STAGES].width)
                            && (stage_ff[DIV_STAGES].key.rem < stage_ff[DIV_STAGES].width))
      else $error("divider remainder not below mesh width");

   // A unicast takes exactly one port, or none together with an error.
   a_unicast_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !bcast_out_ff |->
         ($onehot(rsp_port_mask) && !rsp_route_error)
         || (rsp_port_mask == '0 && rsp_route_error))
      else $error("unicast result is malformed");

   // A broadcast always delivers locally and never reports an error.
   a_bcast_local: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bcast_out_ff |-> rsp_port_mask[PORT_LOCAL] && !rsp_route_error)
      else $error("broadcast result is malformed");

   // An empty input stage always takes a request.
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> req_ready)
      else $error("empty input stage refused a request");

   // A stalled output holds its result in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(port_mask_ff) && $stable(route_error_ff))
      else $error("stalled result changed");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the mesh XY route computation block.
// A directed table is followed by random requests under several mesh settings.
// Every response is checked against a typed-in route or a predictor kept in this file. Depends on mxy_pkg.
`timescale 1ns / 1ps

module testbench;
   import mxy_pkg::*;

   // Index with no register behind it; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int PHASES          = 10;
   localparam int PHASE_REQS      = 75;
   localparam int PRESSURE_AT     = 340;
   localparam int PRESSURE_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 12;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              err;
   } route_type;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   // One line of the directed table: a register write or a request.
   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [NODE_W-1:0]    data;   // register value, or the sender of a request
      logic [NODE_W-1:0]    dst;
      logic                 bcast;
      logic                 typed;  // expected route typed in below
      logic [MASK_W-1:0]    mask;
      logic                 err;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [NODE_W-1:0]     req_src_node;
   logic [NODE_W-1:0]     req_dst_node;
   logic                  req_is_broadcast;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [MASK_W-1:0]     rsp_port_mask;
   logic                  rsp_route_error;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Register values as this testbench believes them to be.
   logic [DIM_W-1:0]  cfg_width  = 7'd8;
   logic [DIM_W-1:0]  cfg_height = 7'd8;
   logic [NODE_W-1:0] cfg_own    = '0;

   route_type pending_routes[$];
   int        mismatches = 0;
   bit        no_idle    = 1'b0;

   row_type plan [0:39] = '{
      // Reset mesh of 8 by 8, this router at the corner node 0.
      '{ROW_REQ, '0, 12'd0,    12'd0,    1'b0, 1'b1, 5'b00001, 1'b0},
      '{ROW_REQ, '0, 12'd4095, 12'd7,    1'b0, 1'b1, 5'b00100, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd8,    1'b0, 1'b1, 5'b10000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd4095, 1'b1, 1'b1, 5'b10101, 1'b0},
      // Opposite corner.
      '{ROW_CSR, CSR_OWN_NODE, 12'd63, 12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd0,    1'b0, 1'b1, 5'b00010, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd63,   1'b0, 1'b1, 5'b00001, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd71,   1'b0, 1'b1, 5'b00000, 1'b1},
      '{ROW_REQ, '0, 12'd63,   12'd0,    1'b1, 1'b1, 5'b01011, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd0,    1'b1, 1'b1, 5'b00001, 1'b0},
      // Router placed far outside the mesh.
      '{ROW_CSR, CSR_OWN_NODE, 12'd4095, 12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd0,    1'b0, 1'b1, 5'b00000, 1'b1},
      '{ROW_REQ, '0, 12'd4095, 12'd0,    1'b1, 1'b1, 5'b00001, 1'b0},
      // Zero width is taken as one column, an oversized height as the maximum.
      '{ROW_CSR, CSR_MESH_WIDTH,  12'd0,   12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_CSR, CSR_MESH_HEIGHT, 12'd127, 12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_CSR, CSR_OWN_NODE,    12'd0,   12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd4095, 1'b0, 1'b1, 5'b10000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd0,    1'b0, 1'b1, 5'b00001, 1'b0},
      '{ROW_REQ, '0, 12'd4095, 12'd0,    1'b1, 1'b1, 5'b00001, 1'b0},
      // Oversized width, zero height, router off the single row.
      '{ROW_CSR, CSR_MESH_WIDTH,  12'd127,  12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_CSR, CSR_MESH_HEIGHT, 12'd0,    12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_CSR, CSR_OWN_NODE,    12'd4095, 12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd0,    1'b0, 1'b1, 5'b00000, 1'b1},
      '{ROW_REQ, '0, 12'd4095, 12'd4095, 1'b1, 1'b1, 5'b00001, 1'b0},
      // Largest mesh, router in the middle.
      '{ROW_CSR, CSR_MESH_WIDTH,  12'd64,   12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_CSR, CSR_MESH_HEIGHT, 12'd64,   12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_CSR, CSR_OWN_NODE,    12'd2080, 12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd2080, 1'b0, 1'b1, 5'b00001, 1'b0},
      '{ROW_REQ, '0, 12'd2080, 12'd0,    1'b1, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd0,    1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd4095, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd2144, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd2016, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd4095, 12'd0,    1'b1, 1'b0, 5'b00000, 1'b0},
      // Single node mesh; upper data bits of a dimension write are dropped.
      '{ROW_CSR, CSR_SPARE,       12'hFFF, 12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_CSR, CSR_MESH_WIDTH,  12'hF81, 12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_CSR, CSR_MESH_HEIGHT, 12'h001, 12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_CSR, CSR_OWN_NODE,    12'd0,   12'd0, 1'b0, 1'b0, 5'b00000, 1'b0},
      '{ROW_REQ, '0, 12'd0,    12'd4095, 1'b0, 1'b1, 5'b00000, 1'b1},
      '{ROW_REQ, '0, 12'd0,    12'd0,    1'b1, 1'b1, 5'b00001, 1'b0}
   };

   mesh_xy_route_compute dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_node     (req_src_node),
      .req_dst_node     (req_dst_node),
      .req_is_broadcast (req_is_broadcast),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_port_mask    (rsp_port_mask),
      .rsp_route_error  (rsp_route_error),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Safety net against a hung handshake.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // A zero dimension counts as one; anything past the maximum is clipped.
   function automatic int dim_used(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return int'(v);
   endfunction

   function automatic bit on_grid(int x, int y, int w, int h);
      return x >= 0 && x < w && y >= 0 && y < h;
   endfunction

   // Ports that a head flit leaves by, under the current register values.
   function automatic route_type route_for(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                                           logic bcast);
      int        w, h, cx, cy, sx, sy, dx, dy, nx, ny, hop;
      route_type r;
      w  = dim_used(cfg_width);
      h  = dim_used(cfg_height);
      cx = int'(cfg_own) % w;
      cy = int'(cfg_own) / w;
      r  = '0;
      if (bcast) begin
         // Tree broadcast: vertical spread everywhere, horizontal in the sender's row.
         sx = int'(src) % w;
         sy = int'(src) / w;
         if (cy >= sy && on_grid(cx, cy + 1, w, h)) r.mask[PORT_NORTH] = 1'b1;
         if (cy <= sy && on_grid(cx, cy - 1, w, h)) r.mask[PORT_SOUTH] = 1'b1;
         if (cy == sy) begin
            if (cx >= sx && on_grid(cx + 1, cy, w, h)) r.mask[PORT_EAST] = 1'b1;
            if (cx <= sx && on_grid(cx - 1, cy, w, h)) r.mask[PORT_WEST] = 1'b1;
         end
         r.mask[PORT_LOCAL] = 1'b1;
      end else begin
         // X first, then Y; a hop off the mesh is an error with an empty mask.
         dx = int'(dst) % w;
         dy = int'(dst) / w;
         nx = cx;
         ny = cy;
         if (cx > dx) begin
            nx = cx - 1;
            hop = PORT_WEST;
         end else if (cx < dx) begin
            nx = cx + 1;
            hop = PORT_EAST;
         end else if (cy > dy) begin
            ny = cy - 1;
            hop = PORT_SOUTH;
         end else if (cy < dy) begin
            ny = cy + 1;
            hop = PORT_NORTH;
         end else begin
            hop = PORT_LOCAL;
         end
         if (hop == PORT_LOCAL || on_grid(nx, ny, w, h)) r.mask[hop] = 1'b1;
         else r.err = 1'b1;
      end
      return r;
   endfunction

   // Offers one request, with an occasional gap first, and records its route once taken.
   task automatic send_req(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst, logic bcast,
                           route_type want);
      int gap;
      csr_wr_en <= 1'b0;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_src_node     <= src;
      req_dst_node     <= dst;
      req_is_broadcast <= bcast;
      do @(posedge clock); while (!req_ready);
      pending_routes = {pending_routes, want};
   endtask

   // Stops offering and waits until every outstanding response is back.
   task automatic finish_pending();
      req_valid <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
   endtask

   // One register write; the write enable stays up for a following write.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MESH_WIDTH:  cfg_width  = data[DIM_W-1:0];
         CSR_MESH_HEIGHT: cfg_height = data[DIM_W-1:0];
         CSR_OWN_NODE:    cfg_own    = data[NODE_W-1:0];
         default: ;
      endcase
   endtask

   // Response side: checks each accepted response and stalls in random bursts,
   // once for a long stretch so that the pipeline fills and blocks requests.
   initial begin
      int        stall;
      bit        held;
      int        got;
      route_type want;
      stall     = 0;
      held      = 1'b0;
      got       = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got++;
            if (pending_routes.size() == 0) begin
               $display("%0t: response with none expected: port_mask %b route_error %b",
                        $time, rsp_port_mask, rsp_route_error);
               mismatches++;
            end else begin
               want = pending_routes.pop_front();
               if (rsp_port_mask !== want.mask) begin
                  $display("%0t: port_mask expected %b, actual %b",
                           $time, want.mask, rsp_port_mask);
                  mismatches++;
               end
               if (rsp_route_error !== want.err) begin
                  $display("%0t: route_error expected %b, actual %b",
                           $time, want.err, rsp_route_error);
                  mismatches++;
               end
            end
         end
         if (stall > 0) stall--;
         else if (!held && got >= PRESSURE_AT) begin
            stall = PRESSURE_CYCLES;
            held  = 1'b1;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 10);
         end
         rsp_ready <= !reset && stall == 0;
      end
   end

   // Stimulus: the directed table, then random phases under random mesh settings.
   initial begin
      int                    i, ph, k, span, pick;
      logic [DIM_W-1:0]      dim;
      logic [CSR_DATA_W-1:0] dim_data;
      logic [NODE_W-1:0]     src, dst, own;
      logic                  bcast;
      route_type             want;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_src_node     = '0;
      req_dst_node     = '0;
      req_is_broadcast = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_MESH_WIDTH;
      csr_wdata        = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(plan); i++) begin
         if (plan[i].kind == ROW_CSR) begin
            finish_pending();
            write_csr(plan[i].idx, plan[i].data);
         end else begin
            if (plan[i].typed) begin
               want.mask = plan[i].mask;
               want.err  = plan[i].err;
            end else begin
               want = route_for(plan[i].data, plan[i].dst, plan[i].bcast);
            end
            send_req(plan[i].data, plan[i].dst, plan[i].bcast, want);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         finish_pending();
         // The last phase runs at full rate on both sides.
         if (ph == PHASES - 1) no_idle = 1'b1;

         // Mostly small meshes, with the odd degenerate or oversized dimension.
         for (k = 0; k < 2; k++) begin
            case ($urandom_range(0, 9))
               0:       dim = 7'd0;
               1:       dim = 7'd127;
               2:       dim = 7'($urandom_range(MAX_DIM_DEF, 127));
               3:       dim = 7'd1;
               default: dim = 7'($urandom_range(2, 12));
            endcase
            dim_data = CSR_DATA_W'($urandom);
            dim_data[DIM_W-1:0] = dim;
            write_csr(k == 0 ? CSR_MESH_WIDTH : CSR_MESH_HEIGHT, dim_data);
         end
         span = dim_used(cfg_width) * dim_used(cfg_height);
         if (span > 4096) span = 4096;
         if ($urandom_range(0, 3) == 0) own = 12'($urandom_range(0, 4095));
         else own = 12'($urandom_range(0, span - 1));
         write_csr(CSR_OWN_NODE, own);

         for (k = 0; k < PHASE_REQS; k++) begin
            bcast = $urandom_range(0, 9) < 3;
            pick  = $urandom_range(0, 9);
            if (pick < 2) begin
               // Arbitrary ids, mostly off the mesh.
               src = 12'($urandom_range(0, 4095));
               dst = 12'($urandom_range(0, 4095));
            end else begin
               src = 12'($urandom_range(0, span - 1));
               dst = pick == 2 ? cfg_own : 12'($urandom_range(0, span - 1));
            end
            send_req(src, dst, bcast, route_for(src, dst, bcast));
         end
      end

      finish_pending();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
